[design/flight_mode_geofence_supervisor_assert.svh]
// assertion macros shared by the supervisor modules
`ifndef FLIGHT_MODE_GEOFENCE_SUPERVISOR_ASSERT_SVH
`define FLIGHT_MODE_GEOFENCE_SUPERVISOR_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define FMGS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");
// next-cycle implication
`define FMGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");
`else
`define FMGS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FMGS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/fmgs_pkg.sv]
package fmgs_pkg;

   // field widths
   localparam int POS_W = 32;
   localparam int PWM_W = 12;
   localparam int HDG_W = 16;
   localparam int LIM_W = 31;
   localparam int CSR_IDX_W = 2;
   localparam int CMP_W = (POS_W > LIM_W) ? POS_W : LIM_W;

   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic [POS_W-1:0]        mag_type;
   typedef logic signed [HDG_W-1:0] hdg_type;
   typedef logic [PWM_W-1:0]        pwm_type;
   typedef logic [LIM_W-1:0]        limit_type;
   typedef logic [CSR_IDX_W-1:0]    csr_index_type;

   // tick codes
   typedef enum logic [1:0] {
      CMD_MODE    = 2'd0,
      CMD_SAFETY  = 2'd1,
      CMD_CONTROL = 2'd2
   } command_type;

   // flight modes
   typedef enum logic [1:0] {
      MODE_POSITION = 2'd0,
      MODE_HOLD     = 2'd1,
      MODE_COMMAND  = 2'd2
   } mode_type;

   // setpoint origin
   typedef enum logic [1:0] {
      SRC_NONE        = 2'd0,
      SRC_SWITCH_HOLD = 2'd1,
      SRC_SAFE_HOLD   = 2'd2,
      SRC_TARGET      = 2'd3
   } source_type;

   // rejection reasons
   typedef enum logic [1:0] {
      REJ_NONE     = 2'd0,
      REJ_FENCE    = 2'd1,
      REJ_OFFBOARD = 2'd2
   } reject_type;

   // register indexes
   localparam csr_index_type CSR_FENCE_X      = 2'd0;
   localparam csr_index_type CSR_FENCE_Y      = 2'd1;
   localparam csr_index_type CSR_FENCE_HEIGHT = 2'd2;

   // register reset values
   localparam limit_type FENCE_X_RESET      = 31'd655360;
   localparam limit_type FENCE_Y_RESET      = 31'd655360;
   localparam limit_type FENCE_HEIGHT_RESET = 31'd327680;

   // pwm decode thresholds in microseconds
   localparam pwm_type PWM_POS_LO  = 12'd900;
   localparam pwm_type PWM_POS_HI  = 12'd1200;
   localparam pwm_type PWM_HOLD_LO = 12'd1300;
   localparam pwm_type PWM_HOLD_HI = 12'd1600;
   localparam pwm_type PWM_HIGH_LO = 12'd1700;
   localparam pwm_type PWM_HIGH_HI = 12'd2100;
   localparam pwm_type PWM_DISARM  = 12'd1000;
   localparam pwm_type PWM_ARM     = 12'd2000;

   typedef struct packed {
      limit_type x;
      limit_type y;
      limit_type height;
   } limits_type;

   typedef struct packed {
      logic [1:0] command;
      pwm_type    rc_arm_ch;
      pwm_type    rc_aux_ch;
      pwm_type    rc_mode_ch;
      logic       in_offboard;
      logic       is_armed;
      pos_type    pos_x;
      pos_type    pos_y;
      pos_type    pos_z;
      hdg_type    heading;
   } req_item_type;

   typedef struct packed {
      logic       setpoint_valid;
      source_type setpoint_source;
      pos_type    set_x;
      pos_type    set_y;
      pos_type    set_z;
      hdg_type    set_heading;
      logic       request_offboard;
      logic       request_arm;
      mode_type   mode_now;
      logic       breach_now;
      reject_type reject_code;
   } rsp_item_type;

   // strict band check lo < v < hi
   function automatic logic pwm_in_band(input pwm_type v, input pwm_type lo,
                                        input pwm_type hi);
      return (v > lo) && (v < hi);
   endfunction

   // absolute value, exact for the most negative code
   function automatic mag_type pos_mag(input pos_type v);
      mag_type u;
      u = mag_type'(v);
      return v[POS_W-1] ? mag_type'(~u + 1'b1) : u;
   endfunction

   // magnitude above a limit
   function automatic logic above_limit(input mag_type m, input limit_type lim);
      return CMP_W'(m) > CMP_W'(lim);
   endfunction

endpackage

[design/fmgs_ifs.sv]
// input tick channel
interface fmgs_req_if import fmgs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] command;
   pwm_type    rc_arm_ch;
   pwm_type    rc_aux_ch;
   pwm_type    rc_mode_ch;
   logic       in_offboard;
   logic       is_armed;
   pos_type    pos_x;
   pos_type    pos_y;
   pos_type    pos_z;
   hdg_type    heading;

   modport source (output valid, command, rc_arm_ch, rc_aux_ch, rc_mode_ch, in_offboard,
                   is_armed, pos_x, pos_y, pos_z, heading, input ready);
   modport sink (input valid, command, rc_arm_ch, rc_aux_ch, rc_mode_ch, in_offboard,
                 is_armed, pos_x, pos_y, pos_z, heading, output ready);
endinterface

// result channel
interface fmgs_rsp_if import fmgs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       setpoint_valid;
   source_type setpoint_source;
   pos_type    set_x;
   pos_type    set_y;
   pos_type    set_z;
   hdg_type    set_heading;
   logic       request_offboard;
   logic       request_arm;
   mode_type   mode_now;
   logic       breach_now;
   reject_type reject_code;

   modport source (output valid, setpoint_valid, setpoint_source, set_x, set_y, set_z,
                   set_heading, request_offboard, request_arm, mode_now, breach_now,
                   reject_code, input ready);
   modport sink (input valid, setpoint_valid, setpoint_source, set_x, set_y, set_z,
                 set_heading, request_offboard, request_arm, mode_now, breach_now,
                 reject_code, output ready);
endinterface

// register write channel
interface fmgs_csr_if import fmgs_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   limit_type     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[design/flight_mode_geofence_supervisor.sv]
// path: an accepted tick waits in the input register, and its result is written to the result
// register once that register is empty or its result is being taken
// throughput: one tick per cycle while the result channel is ready, set by a single pass
// through the supervisor logic between the input register and the result register
// reset: synchronous, active high; restores fence limits, position mode, breach latched
// and all hold points to zero, and empties both pipeline registers
`include "flight_mode_geofence_supervisor_assert.svh"

module flight_mode_geofence_supervisor import fmgs_pkg::*; (
   input logic        clock,
   input logic        reset,
   fmgs_req_if.sink   req_bus,
   fmgs_rsp_if.source rsp_bus,
   fmgs_csr_if.sink   csr_bus
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   req_item_type req_item;
   rsp_item_type core_result;
   limits_type   limits;
   logic         req_xfer;
   logic         stage_advance;

   fmgs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .limits  (limits)
   );

   // input channel payload
   assign req_item.command = req_bus.command;
   assign req_item.rc_arm_ch = req_bus.rc_arm_ch;
   assign req_item.rc_aux_ch = req_bus.rc_aux_ch;
   assign req_item.rc_mode_ch = req_bus.rc_mode_ch;
   assign req_item.in_offboard = req_bus.in_offboard;
   assign req_item.is_armed = req_bus.is_armed;
   assign req_item.pos_x = req_bus.pos_x;
   assign req_item.pos_y = req_bus.pos_y;
   assign req_item.pos_z = req_bus.pos_z;
   assign req_item.heading = req_bus.heading;

   // pipeline handshake
   assign stage_advance = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || stage_advance;
   assign req_xfer = req_bus.valid && req_bus.ready;

   fmgs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (stage_advance),
      .item    (in_item_ff),
      .limits  (limits),
      .result  (core_result)
   );

   // input and result register next values
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in = in_item_ff;
      out_valid_in = out_valid_ff;
      out_item_in = out_item_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
         in_item_in = req_item;
      end else if (stage_advance) begin
         in_valid_in = 1'b0;
      end
      if (stage_advance) begin
         out_valid_in = 1'b1;
         out_item_in = core_result;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_item_ff <= out_item_in;
   end

   // result channel
   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.setpoint_valid = out_item_ff.setpoint_valid;
   assign rsp_bus.setpoint_source = out_item_ff.setpoint_source;
   assign rsp_bus.set_x = out_item_ff.set_x;
   assign rsp_bus.set_y = out_item_ff.set_y;
   assign rsp_bus.set_z = out_item_ff.set_z;
   assign rsp_bus.set_heading = out_item_ff.set_heading;
   assign rsp_bus.request_offboard = out_item_ff.request_offboard;
   assign rsp_bus.request_arm = out_item_ff.request_arm;
   assign rsp_bus.mode_now = out_item_ff.mode_now;
   assign rsp_bus.breach_now = out_item_ff.breach_now;
   assign rsp_bus.reject_code = out_item_ff.reject_code;

   // a processed tick always lands in the result register
   `FMGS_ASSERT_NEXT(a_advance_fills_output, clock, reset, stage_advance, out_valid_ff)
   // a held tick is not lost
   `FMGS_ASSERT_NEXT(a_input_held, clock, reset, in_valid_ff && !stage_advance, in_valid_ff)
   // a new transfer onto a full input register requires it to drain
   `FMGS_ASSERT_IMPL(a_no_overwrite, clock, reset, in_valid_ff && req_bus.ready, stage_advance)

endmodule

[design/fmgs_csr.sv]
module fmgs_csr import fmgs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   fmgs_csr_if.sink   csr_bus,
   output limits_type limits
);

   limit_type fence_x_ff, fence_x_in;
   limit_type fence_y_ff, fence_y_in;
   limit_type fence_height_ff, fence_height_in;
   logic      write_en;

   // writes are always taken
   assign csr_bus.ready = 1'b1;
   assign write_en = csr_bus.valid;

   // register decode, unknown indexes ignored
   always_comb begin
      fence_x_in = fence_x_ff;
      fence_y_in = fence_y_ff;
      fence_height_in = fence_height_ff;
      if (write_en) begin
         case (csr_bus.index)
            CSR_FENCE_X: fence_x_in = csr_bus.data;
            CSR_FENCE_Y: fence_y_in = csr_bus.data;
            CSR_FENCE_HEIGHT: fence_height_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fence_x_ff <= FENCE_X_RESET;
         fence_y_ff <= FENCE_Y_RESET;
         fence_height_ff <= FENCE_HEIGHT_RESET;
      end else begin
         fence_x_ff <= fence_x_in;
         fence_y_ff <= fence_y_in;
         fence_height_ff <= fence_height_in;
      end
   end

   assign limits.x = fence_x_ff;
   assign limits.y = fence_y_ff;
   assign limits.height = fence_height_ff;

endmodule

[design/fmgs_core.sv]
`include "flight_mode_geofence_supervisor_assert.svh"

module fmgs_core import fmgs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_item_type item,
   input  limits_type   limits,
   output rsp_item_type result
);

   mode_type flight_mode_ff, flight_mode_in;
   logic     arm_enable_ff, arm_enable_in;
   logic     offboard_missing_ff, offboard_missing_in;
   logic     fence_breached_ff, fence_breached_in;
   logic     fence_update_ok_ff, fence_update_ok_in;
   pwm_type  last_mode_pwm_ff, last_mode_pwm_in;
   pos_type  switch_hold_x_ff, switch_hold_x_in;
   pos_type  switch_hold_y_ff, switch_hold_y_in;
   pos_type  switch_hold_z_ff, switch_hold_z_in;
   hdg_type  switch_hold_heading_ff, switch_hold_heading_in;
   pos_type  safe_hold_x_ff, safe_hold_x_in;
   pos_type  safe_hold_y_ff, safe_hold_y_in;
   pos_type  safe_hold_z_ff, safe_hold_z_in;
   hdg_type  safe_hold_heading_ff, safe_hold_heading_in;

   logic aux_ok;
   logic mode_changed;
   logic x_over;
   logic y_over;
   logic z_over;
   logic z_high;
   logic pose_outside;
   logic target_bad;

   // shared decode and fence compares
   assign aux_ok = pwm_in_band(item.rc_aux_ch, PWM_HIGH_LO, PWM_HIGH_HI);
   assign mode_changed = item.rc_mode_ch != last_mode_pwm_ff;
   assign x_over = above_limit(pos_mag(item.pos_x), limits.x);
   assign y_over = above_limit(pos_mag(item.pos_y), limits.y);
   assign z_over = above_limit(pos_mag(item.pos_z), limits.height);
   // positive height over the limit, negative heights pass the target check
   assign z_high = !item.pos_z[POS_W-1] && z_over;
   assign pose_outside = x_over || y_over || z_over;
   assign target_bad = z_high || x_over || y_over;

   // tick processing and next state
   always_comb begin
      flight_mode_in = flight_mode_ff;
      arm_enable_in = arm_enable_ff;
      offboard_missing_in = offboard_missing_ff;
      fence_breached_in = fence_breached_ff;
      fence_update_ok_in = fence_update_ok_ff;
      last_mode_pwm_in = last_mode_pwm_ff;
      switch_hold_x_in = switch_hold_x_ff;
      switch_hold_y_in = switch_hold_y_ff;
      switch_hold_z_in = switch_hold_z_ff;
      switch_hold_heading_in = switch_hold_heading_ff;
      safe_hold_x_in = safe_hold_x_ff;
      safe_hold_y_in = safe_hold_y_ff;
      safe_hold_z_in = safe_hold_z_ff;
      safe_hold_heading_in = safe_hold_heading_ff;

      result = '0;
      result.setpoint_source = SRC_NONE;
      result.reject_code = REJ_NONE;

      case (item.command)
         CMD_MODE: begin
            // mode switch latches the pose as hold point
            if (mode_changed) begin
               switch_hold_x_in = item.pos_x;
               switch_hold_y_in = item.pos_y;
               switch_hold_z_in = item.pos_z;
               switch_hold_heading_in = item.heading;
               if (pwm_in_band(item.rc_mode_ch, PWM_HOLD_LO, PWM_HOLD_HI) && aux_ok) begin
                  flight_mode_in = MODE_HOLD;
                  fence_update_ok_in = 1'b1;
                  fence_breached_in = 1'b0;
               end else if (pwm_in_band(item.rc_mode_ch, PWM_HIGH_LO, PWM_HIGH_HI)
                            && aux_ok) begin
                  flight_mode_in = MODE_COMMAND;
               end else begin
                  flight_mode_in = MODE_POSITION;
                  fence_update_ok_in = 1'b1;
                  fence_breached_in = 1'b0;
               end
            end
            last_mode_pwm_in = item.rc_mode_ch;
            // arm switch end positions only
            if (item.rc_arm_ch == PWM_DISARM) begin
               arm_enable_in = 1'b0;
            end else if (item.rc_arm_ch == PWM_ARM) begin
               arm_enable_in = 1'b1;
            end
         end
         CMD_SAFETY: begin
            // offboard and arm requests outside position mode
            if (flight_mode_ff == MODE_HOLD || flight_mode_ff == MODE_COMMAND) begin
               if (!item.in_offboard) begin
                  offboard_missing_in = 1'b1;
                  result.request_offboard = 1'b1;
               end else begin
                  offboard_missing_in = 1'b0;
                  result.request_arm = arm_enable_ff && !item.is_armed;
               end
            end
            // fence latch and last in-fence pose
            if (pose_outside) begin
               if (fence_update_ok_ff) begin
                  fence_breached_in = 1'b1;
                  fence_update_ok_in = 1'b0;
               end
            end else if (fence_update_ok_ff) begin
               safe_hold_x_in = item.pos_x;
               safe_hold_y_in = item.pos_y;
               safe_hold_z_in = item.pos_z;
               safe_hold_heading_in = item.heading;
               fence_breached_in = 1'b0;
            end
         end
         CMD_CONTROL: begin
            case (flight_mode_ff)
               MODE_HOLD: begin
                  result.setpoint_valid = 1'b1;
                  result.setpoint_source = SRC_SWITCH_HOLD;
                  result.set_x = switch_hold_x_ff;
                  result.set_y = switch_hold_y_ff;
                  result.set_z = switch_hold_z_ff;
                  result.set_heading = switch_hold_heading_ff;
               end
               MODE_COMMAND: begin
                  // target gate: fence, then offboard, then breach
                  if (target_bad) begin
                     result.reject_code = REJ_FENCE;
                  end else if (offboard_missing_ff) begin
                     result.reject_code = REJ_OFFBOARD;
                  end else if (fence_breached_ff) begin
                     result.setpoint_valid = 1'b1;
                     result.setpoint_source = SRC_SAFE_HOLD;
                     result.set_x = safe_hold_x_ff;
                     result.set_y = safe_hold_y_ff;
                     result.set_z = safe_hold_z_ff;
                     result.set_heading = safe_hold_heading_ff;
                  end else begin
                     result.setpoint_valid = 1'b1;
                     result.setpoint_source = SRC_TARGET;
                     result.set_x = item.pos_x;
                     result.set_y = item.pos_y;
                     result.set_z = item.pos_z;
                     result.set_heading = item.heading;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      result.mode_now = flight_mode_in;
      result.breach_now = fence_breached_in;
   end

   // supervisor state, updated once per processed tick
   always_ff @(posedge clock) begin
      if (reset) begin
         flight_mode_ff <= MODE_POSITION;
         arm_enable_ff <= 1'b0;
         offboard_missing_ff <= 1'b1;
         fence_breached_ff <= 1'b1;
         fence_update_ok_ff <= 1'b1;
         last_mode_pwm_ff <= '0;
         switch_hold_x_ff <= '0;
         switch_hold_y_ff <= '0;
         switch_hold_z_ff <= '0;
         switch_hold_heading_ff <= '0;
         safe_hold_x_ff <= '0;
         safe_hold_y_ff <= '0;
         safe_hold_z_ff <= '0;
         safe_hold_heading_ff <= '0;
      end else if (advance) begin
         flight_mode_ff <= flight_mode_in;
         arm_enable_ff <= arm_enable_in;
         offboard_missing_ff <= offboard_missing_in;
         fence_breached_ff <= fence_breached_in;
         fence_update_ok_ff <= fence_update_ok_in;
         last_mode_pwm_ff <= last_mode_pwm_in;
         switch_hold_x_ff <= switch_hold_x_in;
         switch_hold_y_ff <= switch_hold_y_in;
         switch_hold_z_ff <= switch_hold_z_in;
         switch_hold_heading_ff <= switch_hold_heading_in;
         safe_hold_x_ff <= safe_hold_x_in;
         safe_hold_y_ff <= safe_hold_y_in;
         safe_hold_z_ff <= safe_hold_z_in;
         safe_hold_heading_ff <= safe_hold_heading_in;
      end
   end

   // blocked fence updates only follow a latched breach
   `FMGS_ASSERT_IMPL(a_update_block_implies_breach, clock, reset, !fence_update_ok_ff, fence_breached_ff)
   // arm request only with offboard confirmed outside position mode
   `FMGS_ASSERT_IMPL(a_arm_req_context, clock, reset, advance && result.request_arm, item.in_offboard && (flight_mode_ff != MODE_POSITION))
   // an emitted setpoint carries a source and no rejection
   `FMGS_ASSERT_IMPL(a_setpoint_consistent, clock, reset, result.setpoint_valid, (result.reject_code == REJ_NONE) && (result.setpoint_source != SRC_NONE))
   // a mode channel change latches the hold point
   `FMGS_ASSERT_NEXT(a_switch_hold_latch, clock, reset, advance && (item.command == CMD_MODE) && mode_changed, switch_hold_x_ff == $past(item.pos_x))

endmodule
